@@ sv/luminance_bilateral_filter_top_assert.svh @@
// assertion macros for the luminance bilateral filter
`ifndef LUMINANCE_BILATERAL_FILTER_TOP_ASSERT_SVH
`define LUMINANCE_BILATERAL_FILTER_TOP_ASSERT_SVH

// condition implies consequence in the same cycle
`define LBF_ASSERT_IMPL(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error("lbf assertion failed");

// condition implies consequence in the following cycle
`define LBF_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("lbf assertion failed");

`endif

@@ sv/lbf_pkg.sv @@
// types and constants for the luminance bilateral filter
`default_nettype none
package lbf_pkg;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_FILTER = 1'b1;

    localparam logic [2:0] REG_WIDTH   = 3'd0;
    localparam logic [2:0] REG_HEIGHT  = 3'd1;
    localparam logic [2:0] REG_RADIUS  = 3'd2;
    localparam logic [2:0] REG_SPATIAL = 3'd3;
    localparam logic [2:0] REG_RANGE   = 3'd4;

    // rec.709 luminance weights in q0.16
    localparam logic [15:0] LUMA_WR = 16'd13933;
    localparam logic [15:0] LUMA_WG = 16'd46871;
    localparam logic [15:0] LUMA_WB = 16'd4732;

    typedef enum logic [4:0] {
        S_IDLE,
        S_RD,
        S_LR,
        S_LG,
        S_LB,
        S_DX,
        S_DY,
        S_SPA,
        S_DL2,
        S_RNG,
        S_IDX,
        S_WRD,
        S_AR,
        S_AG,
        S_AB,
        S_DLD,
        S_DIT,
        S_DST,
        S_DONE
    } t_state;

endpackage
`default_nettype wire

@@ sv/luminance_bilateral_filter_top.sv @@
// Bilateral filter over a stored RGB frame. A load request (opcode 0) writes one pixel. A
// filter request (opcode 1) reads the centre pixel, then walks the clipped window tap by tap,
// all multiplies going through one shared 32x32 multiplier, then runs three restoring
// divisions of the SW-bit channel sums (SW = 33 + clog2 of the largest tap count, 43 for the
// default maximum radius). A filter request outside the image gives no result.
// Finished results sit in an output register, so the next request is taken while one waits.
`default_nettype none
module luminance_bilateral_filter_top
    import lbf_pkg::*;
#(
    parameter int MAX_WIDTH       = 256,
    parameter int MAX_HEIGHT      = 256,
    parameter int MAX_RADIUS      = 12,
    parameter int EXP_TABLE_DEPTH = 1024
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic        i_opcode,
    input  wire logic [7:0]  i_pos_x,
    input  wire logic [7:0]  i_pos_y,
    input  wire logic [15:0] i_red_in,
    input  wire logic [15:0] i_green_in,
    input  wire logic [15:0] i_blue_in,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [7:0]       o_out_x,
    output logic [7:0]       o_out_y,
    output logic [15:0]      o_red_out,
    output logic [15:0]      o_green_out,
    output logic [15:0]      o_blue_out,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [23:0] i_cfg_data
);

    localparam int XW   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int YW   = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int MAXD = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
    localparam int CW   = $clog2(MAXD + 256 + MAX_RADIUS) + 1;
    localparam int RW   = $clog2(MAX_RADIUS + 1);
    localparam int D2W  = $clog2(2 * MAX_RADIUS * MAX_RADIUS + 1);
    localparam int AW   = ((D2W + 16) > 28 ? (D2W + 16) : 28) + 1;
    localparam int TAPS = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1);
    localparam int SW   = 33 + $clog2(TAPS);
    localparam int WW   = 18 + $clog2(TAPS);
    localparam int CNW  = $clog2(SW + 2);
    localparam int IW   = $clog2(EXP_TABLE_DEPTH);
    localparam logic [63:0] T_STEP = (64'd16 << 32) / EXP_TABLE_DEPTH;

    typedef logic [16:0] t_exp_tab [EXP_TABLE_DEPTH];

    // exp(-16 i / depth) in q1.16, built from a taylor series of the step base
    function automatic t_exp_tab build_exp();
        t_exp_tab     tab;
        logic [127:0] base;
        logic [127:0] term;
        logic [127:0] cur;
        base = 128'd1 << 32;
        term = 128'd1 << 32;
        cur  = 128'd1 << 32;
        for (int k = 1; k <= 12; k++) begin
            term = ((term * 128'(T_STEP)) >> 32) / 128'(k);
            if (k[0]) begin
                base = base - term;
            end else begin
                base = base + term;
            end
        end
        for (int i = 0; i < EXP_TABLE_DEPTH; i++) begin
            tab[i] = 17'((cur + 128'd32768) >> 16);
            cur    = (cur * base) >> 32;
        end
        return tab;
    endfunction

    localparam t_exp_tab EXP_TAB = build_exp();

    t_state r_state, n_state;

    logic [8:0]  r_cfg_w, r_cfg_h;
    logic [3:0]  r_cfg_r;
    logic [15:0] r_cfg_sc;
    logic [23:0] r_cfg_rc;

    logic [47:0] r_mem [2**(XW+YW)];
    logic [47:0] r_pix, r_cpix;

    logic [CW-1:0] r_px, r_py, r_nx, r_ny, r_x0, r_x1, r_y0, r_y1;
    logic [7:0]    r_ox, r_oy;
    logic          r_centre;
    logic [32:0]   r_lacc;
    logic [15:0]   r_lc, r_ln;
    logic [D2W-1:0] r_d2;
    logic [AW-1:0] r_arg;
    logic [31:0]   r_dl2;
    logic [31:0]   r_idx;
    logic [16:0]   r_wt;
    logic [SW-1:0] r_sum [3];
    logic [WW-1:0] r_sumw;

    logic [1:0]     r_ch;
    logic [CNW-1:0] r_dcnt;
    logic [SW:0]    r_quo;
    logic [WW-1:0]  r_rem;
    logic [15:0]    r_res [3];

    logic        r_ovalid;
    logic [7:0]  r_out_x, r_out_y;
    logic [15:0] r_out_r, r_out_g, r_out_b;

    logic [31:0] m_a, m_b;
    logic [63:0] m_p;

    logic          in_acc, out_free, last_tap, in_image;
    logic [CW-1:0] cw, ch, cr, ipx, ipy;
    logic [CW-1:0] dxd, dyd;
    logic [15:0]   dl;
    logic [33:0]   luma_sum;
    logic [WW:0]   div_sh;
    logic [WW:0]   div_diff;
    logic [SW:0]   quo_sat;

    assign in_acc   = i_valid && o_ready;
    assign out_free = !r_ovalid || i_ready;
    assign last_tap = (r_nx == r_x1) && (r_ny == r_y1);

    always_comb begin
        ipx = CW'(i_pos_x);
        ipy = CW'(i_pos_y);
        cr  = (32'(r_cfg_r) > 32'(MAX_RADIUS)) ? CW'(MAX_RADIUS) : CW'(r_cfg_r);
        if (r_cfg_w == 9'd0) begin
            cw = CW'(1);
        end else if (32'(r_cfg_w) > 32'(MAX_WIDTH)) begin
            cw = CW'(MAX_WIDTH);
        end else begin
            cw = CW'(r_cfg_w);
        end
        if (r_cfg_h == 9'd0) begin
            ch = CW'(1);
        end else if (32'(r_cfg_h) > 32'(MAX_HEIGHT)) begin
            ch = CW'(MAX_HEIGHT);
        end else begin
            ch = CW'(r_cfg_h);
        end
        in_image = (ipx < cw) && (ipy < ch);
        dxd      = (r_nx > r_px) ? (r_nx - r_px) : (r_px - r_nx);
        dyd      = (r_ny > r_py) ? (r_ny - r_py) : (r_py - r_ny);
        dl       = (r_ln > r_lc) ? (r_ln - r_lc) : (r_lc - r_ln);
        luma_sum = 34'(r_lacc) + 34'(m_p[32:0]) + 34'd32768;
        div_sh   = {r_rem, r_quo[SW]};
        div_diff = div_sh - {1'b0, r_sumw};
        quo_sat  = (r_quo > (SW+1)'(16'hFFFF)) ? (SW+1)'(16'hFFFF) : r_quo;
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc && i_opcode == OP_FILTER && in_image) begin
                    n_state = S_RD;
                end
            end
            S_RD:  n_state = S_LR;
            S_LR:  n_state = S_LG;
            S_LG:  n_state = S_LB;
            S_LB:  n_state = r_centre ? S_RD : S_DX;
            S_DX:  n_state = S_DY;
            S_DY:  n_state = S_SPA;
            S_SPA: n_state = S_DL2;
            S_DL2: n_state = S_RNG;
            S_RNG: n_state = S_IDX;
            S_IDX: n_state = S_WRD;
            S_WRD: n_state = S_AR;
            S_AR:  n_state = S_AG;
            S_AG:  n_state = S_AB;
            S_AB:  n_state = last_tap ? S_DLD : S_RD;
            S_DLD: n_state = S_DIT;
            S_DIT: n_state = (r_dcnt == CNW'(SW)) ? S_DST : S_DIT;
            S_DST: n_state = (r_ch == 2'd2) ? S_DONE : S_DLD;
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs: handshake and shared multiplier operands
    always_comb begin
        o_ready = (r_state == S_IDLE);
        m_a     = '0;
        m_b     = '0;
        case (r_state)
            S_LR: begin
                m_a = 32'(r_pix[47:32]);
                m_b = 32'(LUMA_WR);
            end
            S_LG: begin
                m_a = 32'(r_pix[31:16]);
                m_b = 32'(LUMA_WG);
            end
            S_LB: begin
                m_a = 32'(r_pix[15:0]);
                m_b = 32'(LUMA_WB);
            end
            S_DX: begin
                m_a = 32'(dxd[RW-1:0]);
                m_b = 32'(dxd[RW-1:0]);
            end
            S_DY: begin
                m_a = 32'(dyd[RW-1:0]);
                m_b = 32'(dyd[RW-1:0]);
            end
            S_SPA: begin
                m_a = 32'(r_d2);
                m_b = 32'(r_cfg_sc);
            end
            S_DL2: begin
                m_a = 32'(dl);
                m_b = 32'(dl);
            end
            S_RNG: begin
                m_a = r_dl2;
                m_b = 32'(r_cfg_rc);
            end
            S_IDX: begin
                m_a = 32'(r_arg);
                m_b = 32'(EXP_TABLE_DEPTH);
            end
            S_AR: begin
                m_a = 32'(r_pix[47:32]);
                m_b = 32'(r_wt);
            end
            S_AG: begin
                m_a = 32'(r_pix[31:16]);
                m_b = 32'(r_wt);
            end
            S_AB: begin
                m_a = 32'(r_pix[15:0]);
                m_b = 32'(r_wt);
            end
            default: begin
                m_a = '0;
                m_b = '0;
            end
        endcase
        m_p = 64'(m_a) * 64'(m_b);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cfg_w  <= 9'd256;
            r_cfg_h  <= 9'd256;
            r_cfg_r  <= 4'd3;
            r_cfg_sc <= 16'd2048;
            r_cfg_rc <= 24'd12800;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_WIDTH:   r_cfg_w  <= i_cfg_data[8:0];
                    REG_HEIGHT:  r_cfg_h  <= i_cfg_data[8:0];
                    REG_RADIUS:  r_cfg_r  <= i_cfg_data[3:0];
                    REG_SPATIAL: r_cfg_sc <= i_cfg_data[15:0];
                    REG_RANGE:   r_cfg_rc <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_state == S_DONE && out_free) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // frame store
    always_ff @(posedge i_clk) begin
        if (in_acc && i_opcode == OP_LOAD &&
            32'(i_pos_x) < 32'(MAX_WIDTH) && 32'(i_pos_y) < 32'(MAX_HEIGHT)) begin
            r_mem[{YW'(i_pos_y), XW'(i_pos_x)}] <= {i_red_in, i_green_in, i_blue_in};
        end
        if (r_state == S_RD) begin
            r_pix <= r_mem[{r_ny[YW-1:0], r_nx[XW-1:0]}];
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_px     <= ipx;
                r_py     <= ipy;
                r_nx     <= ipx;
                r_ny     <= ipy;
                r_ox     <= i_pos_x;
                r_oy     <= i_pos_y;
                r_x0     <= (ipx > cr) ? ipx - cr : '0;
                r_y0     <= (ipy > cr) ? ipy - cr : '0;
                r_x1     <= (ipx + cr > cw - CW'(1)) ? cw - CW'(1) : ipx + cr;
                r_y1     <= (ipy + cr > ch - CW'(1)) ? ch - CW'(1) : ipy + cr;
                r_centre <= 1'b1;
                r_sum[0] <= '0;
                r_sum[1] <= '0;
                r_sum[2] <= '0;
                r_sumw   <= '0;
                r_ch     <= 2'd0;
            end
            S_LR: r_lacc <= m_p[32:0];
            S_LG: r_lacc <= r_lacc + m_p[32:0];
            S_LB: begin
                r_ln <= luma_sum[31:16];
                if (r_centre) begin
                    r_lc     <= luma_sum[31:16];
                    r_cpix   <= r_pix;
                    r_centre <= 1'b0;
                    r_nx     <= r_x0;
                    r_ny     <= r_y0;
                end
            end
            S_DX:  r_d2  <= m_p[D2W-1:0];
            S_DY:  r_d2  <= r_d2 + m_p[D2W-1:0];
            S_SPA: r_arg <= m_p[AW-1:0];
            S_DL2: r_dl2 <= m_p[31:0];
            S_RNG: r_arg <= r_arg + m_p[AW+27:28];
            S_IDX: r_idx <= m_p[47:16];
            // past the end of the table the weight is zero
            S_WRD: r_wt <= (r_idx < 32'(EXP_TABLE_DEPTH)) ? EXP_TAB[r_idx[IW-1:0]] : 17'd0;
            S_AR:  r_sum[0] <= r_sum[0] + m_p[SW-1:0];
            S_AG:  r_sum[1] <= r_sum[1] + m_p[SW-1:0];
            S_AB: begin
                r_sum[2] <= r_sum[2] + m_p[SW-1:0];
                r_sumw   <= r_sumw + WW'(r_wt);
                if (r_nx == r_x1) begin
                    r_nx <= r_x0;
                    r_ny <= r_ny + CW'(1);
                end else begin
                    r_nx <= r_nx + CW'(1);
                end
            end
            S_DLD: begin
                r_quo  <= (SW+1)'(r_sum[r_ch]) + (SW+1)'(r_sumw >> 1);
                r_rem  <= '0;
                r_dcnt <= '0;
            end
            S_DIT: begin
                if (!div_diff[WW]) begin
                    r_rem <= div_diff[WW-1:0];
                    r_quo <= {r_quo[SW-1:0], 1'b1};
                end else begin
                    r_rem <= div_sh[WW-1:0];
                    r_quo <= {r_quo[SW-1:0], 1'b0};
                end
                r_dcnt <= r_dcnt + CNW'(1);
            end
            S_DST: begin
                if (r_sumw == '0) begin
                    r_res[r_ch] <= r_cpix[47 - 16 * r_ch -: 16];
                end else begin
                    r_res[r_ch] <= quo_sat[15:0];
                end
                r_ch <= r_ch + 2'd1;
            end
            S_DONE: begin
                if (out_free) begin
                    r_out_x <= r_ox;
                    r_out_y <= r_oy;
                    r_out_r <= r_res[0];
                    r_out_g <= r_res[1];
                    r_out_b <= r_res[2];
                end
            end
            default: ;
        endcase
    end

    assign o_valid     = r_ovalid;
    assign o_out_x     = r_out_x;
    assign o_out_y     = r_out_y;
    assign o_red_out   = r_out_r;
    assign o_green_out = r_out_g;
    assign o_blue_out  = r_out_b;

`include "luminance_bilateral_filter_top_assert.svh"

    `LBF_ASSERT_IMPL(a_sumw_nonzero, (r_state == S_DLD), (r_sumw != '0))
    `LBF_ASSERT_IMPL(a_tap_in_window, (r_state == S_RD && !r_centre),
                     (r_nx >= r_x0 && r_nx <= r_x1 && r_ny >= r_y0 && r_ny <= r_y1))
    `LBF_ASSERT_IMPL(a_div_count, (r_state == S_DIT), (r_dcnt <= CNW'(SW)))
    `LBF_ASSERT_NEXT(a_done_loads, (r_state == S_DONE && out_free), (r_ovalid && r_state == S_IDLE))

endmodule
`default_nettype wire
